### rtl/core/gbtn_pkg.sv
// ----------------------------------------------------------------------------
// gbtn_pkg
// Widths, constants and pipeline types for the three-normal gradient blend.
// ----------------------------------------------------------------------------
`default_nettype none

package gbtn_pkg;

   localparam int COMP_BITS   = 16;
   localparam int FRAC_BITS   = 14;
   localparam int WEIGHT_BITS = 16;
   localparam int WEIGHT_FRAC = 14;
   localparam int EPS_BITS    = 25;
   localparam int EPS_FRAC    = 24;
   localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(17);

   localparam int VEC_BITS = 3 * COMP_BITS;
   localparam int SCALE    = (2 * FRAC_BITS > EPS_FRAC) ? 2 * FRAC_BITS : EPS_FRAC;
   localparam int EPS_SH   = SCALE - EPS_FRAC;

   localparam int PROD_W = 2 * COMP_BITS;
   localparam int DOT_W  = PROD_W + 2;
   localparam int DEN_W  = DOT_W - 1;
   localparam int DN_W   = DOT_W + COMP_BITS;
   localparam int NUM_W  = DN_W + 1;
   localparam int MAG_W  = DN_W;

   localparam int GQ     = 44;
   localparam logic [GQ-1:0] GRAD_CAP = {GQ{1'b1}};
   localparam int PRE_SH = SCALE - FRAC_BITS;
   localparam int SH0    = GQ - PRE_SH;

   localparam int WCL_W = WEIGHT_FRAC + 1;
   localparam int WQ_W  = WCL_W + GQ;
   localparam int V_W   = WQ_W + 3;

   localparam int NORM_W    = 64;
   localparam int NRM_STEPS = 6;
   localparam int U_W       = 30;
   localparam int SQS_W     = 2 * U_W + 2;
   localparam int SQ_W      = SQS_W / 2;
   localparam int SR_REM_W  = SQ_W + 2;

   localparam int OQ   = COMP_BITS - 1;
   localparam int ON_W = U_W + FRAC_BITS + 1;

   localparam int LAT = 5 + (GQ + 1) + 3 + (NRM_STEPS + 1) + 2 + SQ_W + (OQ + 1);

   typedef logic signed [COMP_BITS-1:0] comp_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [GQ-1:0]    rest;
      logic [GQ-1:0]    quo;
      logic             sat;
      logic             neg;
   } grad_lane_type;

   typedef struct packed {
      logic [2:0][COMP_BITS-1:0] n;
      logic [2:0][WCL_W-1:0]     w;
      logic [2:0][DEN_W-1:0]     den;
   } grad_side_type;

   typedef struct packed {
      logic [2:0][U_W-1:0] u;
      logic [2:0]          neg;
      logic                zero;
   } norm_side_type;

   typedef struct packed {
      logic [SR_REM_W-1:0] rem;
      logic [SQ_W-1:0]     root;
      logic [SQS_W-1:0]    rad;
   } sqrt_step_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [OQ-1:0]   rest;
      logic [OQ-1:0]   quo;
   } out_lane_type;

endpackage

`default_nettype wire

### rtl/core/gradient_blend_three_normals.sv
// ----------------------------------------------------------------------------
// gradient_blend_three_normals
// Blends three candidate normals into a base normal through surface gradients
// and renormalizes it in a deep pipeline, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/stall     base normal, three normals, weights
//  rsp_      out        rsp_valid/stall     blended normal, degenerate flag
//  csr_      in         csr_wr_en           epsilon
//
// A new item may enter in every unstalled cycle; the depth is set by the
// bit-serial gradient dividers, the square root and the output dividers.
// Reset clears the valid bits and loads epsilon with 17.
// The pipeline moves unless the output register holds an untaken result and
// the last stage is occupied, so bubbles close up while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_blend_three_normals
   import gbtn_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [VEC_BITS-1:0]        req_base_normal,
   input  wire logic [VEC_BITS-1:0]        req_normal_a,
   input  wire logic signed [WEIGHT_BITS-1:0] req_weight_a,
   input  wire logic [VEC_BITS-1:0]        req_normal_b,
   input  wire logic signed [WEIGHT_BITS-1:0] req_weight_b,
   input  wire logic [VEC_BITS-1:0]        req_normal_c,
   input  wire logic signed [WEIGHT_BITS-1:0] req_weight_c,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [VEC_BITS-1:0]             rsp_blended_normal,
   output logic                            rsp_degenerate,
   input  wire logic                       csr_wr_en,
   input  wire logic [EPS_BITS-1:0]        csr_wr_data
);

   logic [EPS_BITS-1:0] eps_ff;
   logic [DEN_W-1:0]    epsx;
   logic                adv;
   logic [LAT-1:0]      vld_ff;
   logic                rsp_valid_ff;
   logic [VEC_BITS-1:0] rsp_normal_ff;
   logic                rsp_degen_ff;

   logic [2:0][VEC_BITS-1:0]    cand;
   logic [2:0][WEIGHT_BITS-1:0] wts;
   logic [WCL_W-1:0]            wcl_in [3];

   comp_type              n1_ff [3];
   comp_type              p1_ff [3][3];
   logic [WCL_W-1:0]      w1_ff [3];
   logic signed [PROD_W-1:0] pr2_ff [3][3];
   comp_type              n2_ff [3];
   comp_type              p2_ff [3][3];
   logic [WCL_W-1:0]      w2_ff [3];
   logic signed [DOT_W-1:0] d3_ff [3];
   comp_type              n3_ff [3];
   comp_type              p3_ff [3][3];
   logic [WCL_W-1:0]      w3_ff [3];
   logic signed [DN_W-1:0] dn4_ff [3][3];
   logic [DEN_W-1:0]      den4_ff [3];
   comp_type              n4_ff [3];
   comp_type              p4_ff [3][3];
   logic [WCL_W-1:0]      w4_ff [3];
   logic [MAG_W-1:0]      mag5_ff [9];
   logic                  neg5_ff [9];
   grad_side_type         side5_ff;

   grad_lane_type dq_ff [GQ+1][9];
   grad_side_type gs_ff [GQ+1];

   logic [WQ_W-1:0]       wq_ff [9];
   logic                  wqn_ff [9];
   logic [2:0][COMP_BITS-1:0] np_ff;
   logic signed [V_W-1:0] e_in [3][3];
   logic signed [V_W-1:0] a1_ff [3];
   logic signed [V_W-1:0] b1_ff [3];
   logic signed [V_W-1:0] v2_ff [3];

   logic [NORM_W-1:0] nw_ff [NRM_STEPS+1][3];
   logic [2:0]        nneg_ff [NRM_STEPS+1];
   logic              nzero_ff [NRM_STEPS+1];

   logic [2*U_W-1:0]  sq_ff [3];
   norm_side_type     sqs_ff;
   logic [SQS_W-1:0]  rad_ff;
   norm_side_type     rads_ff;

   sqrt_step_type sr_ff [SQ_W];
   norm_side_type ss_ff [SQ_W];

   out_lane_type    od_ff [OQ+1][3];
   logic [SQ_W-1:0] ol_ff [OQ+1];
   norm_side_type   os_ff [OQ+1];

   logic [VEC_BITS-1:0] packed_out;

   assign adv       = !rsp_valid_ff || !rsp_stall || !vld_ff[LAT-1];
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_blended_normal = rsp_normal_ff;
   assign rsp_degenerate     = rsp_degen_ff;

   assign epsx = (eps_ff == '0) ? DEN_W'(1) << EPS_SH : DEN_W'(eps_ff) << EPS_SH;

   assign cand = {req_normal_c, req_normal_b, req_normal_a};
   assign wts  = {req_weight_c, req_weight_b, req_weight_a};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (wts[k][WEIGHT_BITS-1]) begin
            wcl_in[k] = '0;
         end else if (wts[k] > WEIGHT_BITS'(1 << WEIGHT_FRAC)) begin
            wcl_in[k] = WCL_W'(1 << WEIGHT_FRAC);
         end else begin
            wcl_in[k] = wts[k][WCL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= EPS_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= vld_ff[LAT-1];
         end
      end
   end

   // Front end: unpack, dot products, divisors and gradient numerators.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n1_ff[i] <= req_base_normal[i*COMP_BITS +: COMP_BITS];
         end
         for (int k = 0; k < 3; k++) begin
            w1_ff[k] <= wcl_in[k];
            w2_ff[k] <= w1_ff[k];
            w3_ff[k] <= w2_ff[k];
            w4_ff[k] <= w3_ff[k];
            n2_ff[k] <= n1_ff[k];
            n3_ff[k] <= n2_ff[k];
            n4_ff[k] <= n3_ff[k];
            d3_ff[k] <= DOT_W'(pr2_ff[k][0]) + DOT_W'(pr2_ff[k][1]) + DOT_W'(pr2_ff[k][2]);
            if (d3_ff[k] < 0) begin
               den4_ff[k] <= (DEN_W'(-d3_ff[k]) > epsx) ? DEN_W'(-d3_ff[k]) : epsx;
            end else begin
               den4_ff[k] <= (DEN_W'(d3_ff[k]) > epsx) ? DEN_W'(d3_ff[k]) : epsx;
            end
            side5_ff.n[k]   <= n4_ff[k];
            side5_ff.w[k]   <= w4_ff[k];
            side5_ff.den[k] <= den4_ff[k];
            for (int i = 0; i < 3; i++) begin
               p1_ff[k][i]  <= cand[k][i*COMP_BITS +: COMP_BITS];
               p2_ff[k][i]  <= p1_ff[k][i];
               p3_ff[k][i]  <= p2_ff[k][i];
               p4_ff[k][i]  <= p3_ff[k][i];
               pr2_ff[k][i] <= n1_ff[i] * p1_ff[k][i];
               dn4_ff[k][i] <= d3_ff[k] * n3_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [NUM_W-1:0] numv;
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               numv = NUM_W'(dn4_ff[k][i]) - (NUM_W'(p4_ff[k][i]) <<< (2 * FRAC_BITS));
               neg5_ff[3*k+i] <= numv[NUM_W-1];
               mag5_ff[3*k+i] <= numv[NUM_W-1] ? MAG_W'(-numv) : MAG_W'(numv);
            end
         end
      end
   end

   // Gradient dividers: one quotient bit per stage, nine lanes.
   always_ff @(posedge clock) begin
      if (adv) begin
         gs_ff[0] <= side5_ff;
         for (int l = 0; l < 9; l++) begin
            dq_ff[0][l].rem  <= DEN_W'(mag5_ff[l] >> SH0);
            dq_ff[0][l].sat  <= DEN_W'(mag5_ff[l] >> SH0) >= side5_ff.den[l/3];
            dq_ff[0][l].rest <= {mag5_ff[l][SH0-1:0], PRE_SH'(0)};
            dq_ff[0][l].quo  <= '0;
            dq_ff[0][l].neg  <= neg5_ff[l];
         end
      end
   end

   for (genvar s = 1; s <= GQ; s++) begin : g_gdiv
      always_ff @(posedge clock) begin
         logic [DEN_W:0] wr;
         logic           ge;
         if (adv) begin
            gs_ff[s] <= gs_ff[s-1];
            for (int l = 0; l < 9; l++) begin
               wr = {dq_ff[s-1][l].rem, dq_ff[s-1][l].rest[GQ-1]};
               ge = wr >= {1'b0, gs_ff[s-1].den[l/3]};
               dq_ff[s][l].rem  <= ge ? DEN_W'(wr - {1'b0, gs_ff[s-1].den[l/3]})
                                      : DEN_W'(wr);
               dq_ff[s][l].rest <= dq_ff[s-1][l].rest << 1;
               dq_ff[s][l].quo  <= {dq_ff[s-1][l].quo[GQ-2:0], ge};
               dq_ff[s][l].sat  <= dq_ff[s-1][l].sat;
               dq_ff[s][l].neg  <= dq_ff[s-1][l].neg;
            end
         end
      end
   end

   // Weighting and subtraction from the base normal.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            e_in[k][i] = wqn_ff[3*k+i] ? $signed({3'b000, wq_ff[3*k+i]})
                                       : -$signed({3'b000, wq_ff[3*k+i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [GQ-1:0] gm;
      if (adv) begin
         np_ff <= gs_ff[GQ].n;
         for (int l = 0; l < 9; l++) begin
            gm = dq_ff[GQ][l].sat ? GRAD_CAP : dq_ff[GQ][l].quo;
            wq_ff[l]  <= gs_ff[GQ].w[l/3] * gm;
            wqn_ff[l] <= dq_ff[GQ][l].neg;
         end
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= e_in[0][i] + e_in[1][i];
            b1_ff[i] <= (V_W'($signed(np_ff[i])) <<< (2 * FRAC_BITS)) + e_in[2][i];
            v2_ff[i] <= a1_ff[i] + b1_ff[i];
         end
      end
   end

   // Block normalization: magnitudes, then a log shifter over six stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            nw_ff[0][i]   <= v2_ff[i][V_W-1] ? NORM_W'(-v2_ff[i]) : NORM_W'(v2_ff[i]);
            nneg_ff[0][i] <= v2_ff[i][V_W-1];
         end
         nzero_ff[0] <= (v2_ff[0] == '0) && (v2_ff[1] == '0) && (v2_ff[2] == '0);
      end
   end

   for (genvar t = 1; t <= NRM_STEPS; t++) begin : g_norm
      localparam int SH = NORM_W >> t;
      logic [NORM_W-1:0] orw;
      assign orw = nw_ff[t-1][0] | nw_ff[t-1][1] | nw_ff[t-1][2];
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               nw_ff[t][i] <= (orw[NORM_W-1 -: SH] == '0) ? nw_ff[t-1][i] << SH
                                                         : nw_ff[t-1][i];
            end
            nneg_ff[t]  <= nneg_ff[t-1];
            nzero_ff[t] <= nzero_ff[t-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]    <= nw_ff[NRM_STEPS][i][NORM_W-1 -: U_W]
                           * nw_ff[NRM_STEPS][i][NORM_W-1 -: U_W];
            sqs_ff.u[i] <= nw_ff[NRM_STEPS][i][NORM_W-1 -: U_W];
         end
         sqs_ff.neg  <= nneg_ff[NRM_STEPS];
         sqs_ff.zero <= nzero_ff[NRM_STEPS];
         rad_ff  <= SQS_W'(sq_ff[0]) + SQS_W'(sq_ff[1]) + SQS_W'(sq_ff[2]);
         rads_ff <= sqs_ff;
      end
   end

   // Integer square root, one result bit per stage.
   for (genvar t = 0; t < SQ_W; t++) begin : g_sqrt
      sqrt_step_type prev;
      norm_side_type prev_side;
      if (t == 0) begin : g_first
         assign prev      = '{rem: '0, root: '0, rad: rad_ff};
         assign prev_side = rads_ff;
      end else begin : g_next
         assign prev      = sr_ff[t-1];
         assign prev_side = ss_ff[t-1];
      end
      always_ff @(posedge clock) begin
         logic [SR_REM_W+1:0] wr;
         logic [SR_REM_W+1:0] trial;
         logic                ge;
         if (adv) begin
            wr    = {prev.rem, prev.rad[SQS_W-1 -: 2]};
            trial = (SR_REM_W + 2)'({prev.root, 2'b01});
            ge    = wr >= trial;
            sr_ff[t].rem  <= ge ? SR_REM_W'(wr - trial) : SR_REM_W'(wr);
            sr_ff[t].root <= {prev.root[SQ_W-2:0], ge};
            sr_ff[t].rad  <= prev.rad << 2;
            ss_ff[t]      <= prev_side;
         end
      end
   end

   // Output division by the length, with rounding folded into the numerator.
   always_ff @(posedge clock) begin
      logic [ON_W-1:0] num;
      if (adv) begin
         ol_ff[0] <= sr_ff[SQ_W-1].root;
         os_ff[0] <= ss_ff[SQ_W-1];
         for (int i = 0; i < 3; i++) begin
            num = ON_W'({ss_ff[SQ_W-1].u[i], FRAC_BITS'(0)})
                  + ON_W'(sr_ff[SQ_W-1].root >> 1);
            od_ff[0][i].rem  <= SQ_W'(num >> OQ);
            od_ff[0][i].rest <= num[OQ-1:0];
            od_ff[0][i].quo  <= '0;
         end
      end
   end

   for (genvar t = 1; t <= OQ; t++) begin : g_odiv
      always_ff @(posedge clock) begin
         logic [SQ_W:0] wr;
         logic          ge;
         if (adv) begin
            ol_ff[t] <= ol_ff[t-1];
            os_ff[t] <= os_ff[t-1];
            for (int i = 0; i < 3; i++) begin
               wr = {od_ff[t-1][i].rem, od_ff[t-1][i].rest[OQ-1]};
               ge = wr >= {1'b0, ol_ff[t-1]};
               od_ff[t][i].rem  <= ge ? SQ_W'(wr - {1'b0, ol_ff[t-1]}) : SQ_W'(wr);
               od_ff[t][i].rest <= od_ff[t-1][i].rest << 1;
               od_ff[t][i].quo  <= {od_ff[t-1][i].quo[OQ-2:0], ge};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         packed_out[i*COMP_BITS +: COMP_BITS] =
            os_ff[OQ].neg[i] ? -COMP_BITS'(od_ff[OQ][i].quo) : COMP_BITS'(od_ff[OQ][i].quo);
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_normal_ff <= os_ff[OQ].zero ? '0 : packed_out;
         rsp_degen_ff  <= os_ff[OQ].zero;
      end
   end

endmodule

`default_nettype wire
